FILE: sv/km2d_pkg.sv
// ----------------------------------------------------------------------------
// km2d_pkg
// Shared constants, command codes and controller/datapath interface types
// for the 2-D k-means Lloyd pass unit.
// ----------------------------------------------------------------------------
package km2d_pkg;

    localparam int COORD_BITS       = 16;
    localparam int IDX_BITS         = 3;
    localparam int CMD_BITS         = 2;
    localparam int NCLU_BITS        = 4;
    localparam int MOVE_BITS        = 38;
    localparam int ADDR_BITS        = 4;
    localparam int DATA_BITS        = 64;
    localparam int DEF_MAX_CLUSTERS = 8;
    localparam int DEF_COUNT_BITS   = 24;

    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_POINT = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd2;

    localparam logic REG_NUM_CLUSTERS = 1'b0;
    localparam logic REG_THRESHOLD    = 1'b1;
    localparam int   REG_SEL_BIT      = 3;

    localparam logic [NCLU_BITS-1:0] RST_NUM_CLUSTERS = 4'd3;
    localparam logic [MOVE_BITS-1:0] RST_THRESHOLD    = 38'd7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_DIST_SQ,
        OP_DIST_CMP,
        OP_ACCUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MOVE_SQ,
        OP_MOVE_ADD,
        OP_RESULT
    } t_op;

    typedef struct packed {
        logic is_point;
        logic is_last;
        logic cnt_nz;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/kmeans_2d_lloyd_pass_unit.sv
// ----------------------------------------------------------------------------
// kmeans_2d_lloyd_pass_unit
// One Lloyd pass of 2-D k-means in signed Q8.8 with an APB register port.
// ----------------------------------------------------------------------------
// Takes one request at a time and returns one result per request. A load or
// read goes from capture through decode to the result register. A point uses
// one squared-distance unit shared by the k clusters in use, a square step and
// a compare step per centroid. The last point of a pass adds, per nonempty
// cluster in use, a setup step, a 40-step restoring divide of the x and y sums
// in parallel and a movement update (square, then add); an empty one takes only
// the setup step. A new request is taken while a result waits.
// Registers: 0x0 num_clusters (4 bits), 0x8 convergence_threshold (38 bits).
// ----------------------------------------------------------------------------
module kmeans_2d_lloyd_pass_unit import km2d_pkg::*; #(
    parameter  int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter  int COUNT_BITS   = DEF_COUNT_BITS,
    localparam int CLU_W        = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [DATA_BITS-1:0]         pwdata,
    output logic [DATA_BITS-1:0]         prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [CMD_BITS-1:0]          i_command,
    input  logic [IDX_BITS-1:0]          i_cluster_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic                         i_last_point,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [IDX_BITS-1:0]          o_cluster_label,
    output logic [MOVE_BITS-1:0]         o_movement,
    output logic                         o_converged,
    output logic                         o_pass_done,
    output logic signed [COORD_BITS-1:0] o_centroid_x_out,
    output logic signed [COORD_BITS-1:0] o_centroid_y_out
);

    logic [NCLU_BITS-1:0] r_num_clusters;
    logic [MOVE_BITS-1:0] r_threshold;
    t_op                  w_op;
    logic [CLU_W-1:0]     w_addr;
    t_sts                 w_sts;
    logic [CNT_W-1:0]     w_k;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_clusters <= RST_NUM_CLUSTERS;
            r_threshold    <= RST_THRESHOLD;
        end else if (psel && penable && pwrite) begin
            if (paddr[REG_SEL_BIT] == REG_NUM_CLUSTERS) begin
                r_num_clusters <= pwdata[NCLU_BITS-1:0];
            end else begin
                r_threshold <= pwdata[MOVE_BITS-1:0];
            end
        end
    end

    assign prdata = (paddr[REG_SEL_BIT] == REG_THRESHOLD) ? DATA_BITS'(r_threshold)
                                                          : DATA_BITS'(r_num_clusters);

    km2d_ctrl #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .i_k     (w_k),
        .o_op    (w_op),
        .o_addr  (w_addr)
    );

    km2d_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .i_addr           (w_addr),
        .o_sts            (w_sts),
        .o_k              (w_k),
        .i_num_clusters   (r_num_clusters),
        .i_threshold      (r_threshold),
        .i_command        (i_command),
        .i_cluster_index  (i_cluster_index),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_last_point     (i_last_point),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_cluster_label  (o_cluster_label),
        .o_movement       (o_movement),
        .o_converged      (o_converged),
        .o_pass_done      (o_pass_done),
        .o_centroid_x_out (o_centroid_x_out),
        .o_centroid_y_out (o_centroid_y_out)
    );

endmodule

FILE: sv/km2d_ctrl.sv
// ----------------------------------------------------------------------------
// km2d_ctrl
// Sequencer: walks the clusters for labeling, the divider passes on the
// last point of a pass, and the hand-off to the result register.
// ----------------------------------------------------------------------------
module km2d_ctrl import km2d_pkg::*; #(
    parameter  int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter  int COUNT_BITS   = DEF_COUNT_BITS,
    localparam int CLU_W        = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1),
    localparam int SUM_BITS     = COORD_BITS + COUNT_BITS,
    localparam int STEP_W       = $clog2(SUM_BITS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_sts             i_sts,
    input  logic [CNT_W-1:0] i_k,
    output t_op              o_op,
    output logic [CLU_W-1:0] o_addr
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIST_SQ,
        S_DIST_CMP,
        S_ACCUM,
        S_DIV_INIT,
        S_DIV_STEP,
        S_MOVE_SQ,
        S_MOVE_ADD,
        S_RESULT
    } t_state;

    t_state             r_state;
    logic [CLU_W-1:0]   r_clu;
    logic [STEP_W-1:0]  r_step;
    logic               w_clu_last;

    assign w_clu_last = (CNT_W'(r_clu) + CNT_W'(1)) == i_k;
    assign o_addr     = r_clu;
    assign o_ready    = (r_state == S_IDLE);

    always_comb begin
        unique case (r_state)
            S_IDLE:     o_op = OP_CAPTURE;
            S_DECODE:   o_op = OP_LOAD;
            S_DIST_SQ:  o_op = OP_DIST_SQ;
            S_DIST_CMP: o_op = OP_DIST_CMP;
            S_ACCUM:    o_op = OP_ACCUM;
            S_DIV_INIT: o_op = OP_DIV_INIT;
            S_DIV_STEP: o_op = OP_DIV_STEP;
            S_MOVE_SQ:  o_op = OP_MOVE_SQ;
            S_MOVE_ADD: o_op = OP_MOVE_ADD;
            S_RESULT:   o_op = i_sts.out_free ? OP_RESULT : OP_NONE;
            default:    o_op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clu   <= '0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_clu <= '0;
                    if (i_sts.is_point) begin
                        r_state <= S_DIST_SQ;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_DIST_SQ: r_state <= S_DIST_CMP;
                S_DIST_CMP: begin
                    if (w_clu_last) begin
                        r_state <= S_ACCUM;
                    end else begin
                        r_clu   <= r_clu + CLU_W'(1);
                        r_state <= S_DIST_SQ;
                    end
                end
                S_ACCUM: begin
                    r_clu <= '0;
                    if (i_sts.is_last) begin
                        r_state <= S_DIV_INIT;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_DIV_INIT: begin
                    r_step <= '0;
                    if (i_sts.cnt_nz) begin
                        r_state <= S_DIV_STEP;
                    end else if (w_clu_last) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_clu <= r_clu + CLU_W'(1);
                    end
                end
                S_DIV_STEP: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(SUM_BITS - 1)) begin
                        r_state <= S_MOVE_SQ;
                    end
                end
                S_MOVE_SQ: r_state <= S_MOVE_ADD;
                S_MOVE_ADD: begin
                    if (w_clu_last) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_clu   <= r_clu + CLU_W'(1);
                        r_state <= S_DIV_INIT;
                    end
                end
                S_RESULT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/km2d_datapath.sv
// ----------------------------------------------------------------------------
// km2d_datapath
// Centroid and accumulator storage, shared squared-difference unit,
// restoring dividers for the centroid update, and the result register.
// ----------------------------------------------------------------------------
module km2d_datapath import km2d_pkg::*; #(
    parameter  int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter  int COUNT_BITS   = DEF_COUNT_BITS,
    localparam int CLU_W        = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1),
    localparam int SUM_BITS     = COORD_BITS + COUNT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_op                          i_op,
    input  logic [CLU_W-1:0]             i_addr,
    output t_sts                         o_sts,
    output logic [CNT_W-1:0]             o_k,
    input  logic [NCLU_BITS-1:0]         i_num_clusters,
    input  logic [MOVE_BITS-1:0]         i_threshold,
    input  logic [CMD_BITS-1:0]          i_command,
    input  logic [IDX_BITS-1:0]          i_cluster_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic                         i_last_point,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [IDX_BITS-1:0]          o_cluster_label,
    output logic [MOVE_BITS-1:0]         o_movement,
    output logic                         o_converged,
    output logic                         o_pass_done,
    output logic signed [COORD_BITS-1:0] o_centroid_x_out,
    output logic signed [COORD_BITS-1:0] o_centroid_y_out
);

    localparam int SQ_W   = 2 * COORD_BITS + 2;
    localparam int DIST_W = SQ_W + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [SUM_BITS-1:0]   t_sum;

    logic [CMD_BITS-1:0]   r_cmd;
    logic [IDX_BITS-1:0]   r_idx;
    t_coord                r_px;
    t_coord                r_py;
    logic                  r_last;

    t_coord                r_cx  [MAX_CLUSTERS];
    t_coord                r_cy  [MAX_CLUSTERS];
    t_sum                  r_sx  [MAX_CLUSTERS];
    t_sum                  r_sy  [MAX_CLUSTERS];
    logic [COUNT_BITS-1:0] r_cnt [MAX_CLUSTERS];

    logic [SQ_W-1:0]       r_sqx;
    logic [SQ_W-1:0]       r_sqy;
    logic [CLU_W-1:0]      r_best;
    logic [DIST_W-1:0]     r_bestd;
    logic [MOVE_BITS-1:0]  r_move;

    logic [COUNT_BITS-1:0] r_remx;
    logic [COUNT_BITS-1:0] r_remy;
    logic [SUM_BITS-1:0]   r_qx;
    logic [SUM_BITS-1:0]   r_qy;
    logic                  r_negx;
    logic                  r_negy;

    logic                  r_ovalid;

    logic [CLU_W-1:0]      w_idx;
    logic                  w_idx_ok;
    logic                  w_is_point;
    logic [SUM_BITS-1:0]   w_qxs;
    logic [SUM_BITS-1:0]   w_qys;
    t_coord                w_nx;
    t_coord                w_ny;
    t_coord                w_ax;
    t_coord                w_ay;
    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    logic [COORD_BITS:0]   w_mx;
    logic [COORD_BITS:0]   w_my;
    logic [SQ_W-1:0]       w_sqx;
    logic [SQ_W-1:0]       w_sqy;
    logic [DIST_W-1:0]     w_dist;
    logic [MOVE_BITS:0]    w_tot;
    logic [SUM_BITS-1:0]   w_sxu;
    logic [SUM_BITS-1:0]   w_syu;
    logic [COUNT_BITS-1:0] w_div;
    logic [COUNT_BITS:0]   w_tx;
    logic [COUNT_BITS:0]   w_ty;
    logic                  w_gex;
    logic                  w_gey;
    logic                  w_out_free;

    assign w_idx      = CLU_W'(r_idx);
    assign w_idx_ok   = (int'(r_idx) < MAX_CLUSTERS);
    assign w_is_point = (r_cmd == CMD_POINT);
    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        if (i_num_clusters == '0) begin
            o_k = CNT_W'(1);
        end else if (int'(i_num_clusters) > MAX_CLUSTERS) begin
            o_k = CNT_W'(MAX_CLUSTERS);
        end else begin
            o_k = CNT_W'(i_num_clusters);
        end
    end

    assign o_sts.is_point = w_is_point;
    assign o_sts.is_last  = r_last;
    assign o_sts.cnt_nz   = (r_cnt[i_addr] != '0);
    assign o_sts.out_free = w_out_free;

    assign w_qxs = r_negx ? (~r_qx + 1'b1) : r_qx;
    assign w_qys = r_negy ? (~r_qy + 1'b1) : r_qy;
    assign w_nx  = w_qxs[COORD_BITS-1:0];
    assign w_ny  = w_qys[COORD_BITS-1:0];

    assign w_ax = (i_op == OP_MOVE_SQ) ? w_nx : r_px;
    assign w_ay = (i_op == OP_MOVE_SQ) ? w_ny : r_py;
    assign w_dx = (COORD_BITS+1)'(w_ax) - (COORD_BITS+1)'(r_cx[i_addr]);
    assign w_dy = (COORD_BITS+1)'(w_ay) - (COORD_BITS+1)'(r_cy[i_addr]);
    assign w_mx = w_dx[COORD_BITS] ? (~w_dx + 1'b1) : w_dx;
    assign w_my = w_dy[COORD_BITS] ? (~w_dy + 1'b1) : w_dy;
    assign w_sqx = SQ_W'(w_mx) * SQ_W'(w_mx);
    assign w_sqy = SQ_W'(w_my) * SQ_W'(w_my);
    assign w_dist = DIST_W'(r_sqx) + DIST_W'(r_sqy);
    assign w_tot  = (MOVE_BITS+1)'(r_move) + (MOVE_BITS+1)'(w_dist);

    assign w_sxu = r_sx[i_addr];
    assign w_syu = r_sy[i_addr];
    assign w_div = r_cnt[i_addr];
    assign w_tx  = {r_remx, r_qx[SUM_BITS-1]};
    assign w_ty  = {r_remy, r_qy[SUM_BITS-1]};
    assign w_gex = (w_tx >= {1'b0, w_div});
    assign w_gey = (w_ty >= {1'b0, w_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
                r_cx[i]  <= '0;
                r_cy[i]  <= '0;
                r_sx[i]  <= '0;
                r_sy[i]  <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            unique case (i_op)
                OP_LOAD: begin
                    if (r_cmd == CMD_LOAD && w_idx_ok) begin
                        r_cx[w_idx] <= r_px;
                        r_cy[w_idx] <= r_py;
                    end
                end
                OP_ACCUM: begin
                    if (r_cnt[r_best] != COUNT_MAX) begin
                        r_sx[r_best]  <= r_sx[r_best] + t_sum'(r_px);
                        r_sy[r_best]  <= r_sy[r_best] + t_sum'(r_py);
                        r_cnt[r_best] <= r_cnt[r_best] + COUNT_BITS'(1);
                    end
                end
                OP_MOVE_ADD: begin
                    r_cx[i_addr] <= w_nx;
                    r_cy[i_addr] <= w_ny;
                end
                OP_RESULT: begin
                    if (w_is_point && r_last) begin
                        for (int i = 0; i < MAX_CLUSTERS; i++) begin
                            r_sx[i]  <= '0;
                            r_sy[i]  <= '0;
                            r_cnt[i] <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_CAPTURE: begin
                r_cmd  <= i_command;
                r_idx  <= i_cluster_index;
                r_px   <= i_coord_x;
                r_py   <= i_coord_y;
                r_last <= i_last_point;
                r_move <= '0;
            end
            OP_DIST_SQ, OP_MOVE_SQ: begin
                r_sqx <= w_sqx;
                r_sqy <= w_sqy;
            end
            OP_DIST_CMP: begin
                if (i_addr == '0 || w_dist < r_bestd) begin
                    r_bestd <= w_dist;
                    r_best  <= i_addr;
                end
            end
            OP_DIV_INIT: begin
                r_remx <= '0;
                r_remy <= '0;
                r_negx <= w_sxu[SUM_BITS-1];
                r_negy <= w_syu[SUM_BITS-1];
                r_qx   <= w_sxu[SUM_BITS-1] ? (~w_sxu + 1'b1) : w_sxu;
                r_qy   <= w_syu[SUM_BITS-1] ? (~w_syu + 1'b1) : w_syu;
            end
            OP_DIV_STEP: begin
                r_remx <= w_gex ? COUNT_BITS'(w_tx - {1'b0, w_div}) : w_tx[COUNT_BITS-1:0];
                r_remy <= w_gey ? COUNT_BITS'(w_ty - {1'b0, w_div}) : w_ty[COUNT_BITS-1:0];
                r_qx   <= {r_qx[SUM_BITS-2:0], w_gex};
                r_qy   <= {r_qy[SUM_BITS-2:0], w_gey};
            end
            OP_MOVE_ADD: begin
                r_move <= w_tot[MOVE_BITS] ? '1 : w_tot[MOVE_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_op == OP_RESULT) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_RESULT) begin
            o_cluster_label  <= w_is_point ? IDX_BITS'(r_best) : '0;
            o_movement       <= (w_is_point && r_last) ? r_move : '0;
            o_converged      <= w_is_point && r_last && (r_move < i_threshold);
            o_pass_done      <= w_is_point && r_last;
            o_centroid_x_out <= (r_cmd == CMD_READ && w_idx_ok) ? r_cx[w_idx] : '0;
            o_centroid_y_out <= (r_cmd == CMD_READ && w_idx_ok) ? r_cy[w_idx] : '0;
        end
    end

    assign o_valid = r_ovalid;

endmodule
